// File: hw/rtl/csvfs_pkg.sv
package csvfs_pkg;

   // Field slot and buffer limits
   localparam logic [2:0]  FIELD_SLOTS    = 3'd5;
   localparam logic [10:0] FIELD_CAPACITY = 11'd1024;

   // Register reset values
   localparam logic [2:0]  MAX_FIELDS_RESET    = 3'd4;
   localparam logic [10:0] MAX_FIELD_LEN_RESET = 11'd256;

   // Characters of interest
   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_QUOTE = 8'd34;
   localparam logic [7:0] CHAR_COMMA = 8'd44;

   typedef enum logic [0:0] {
      CSR_MAX_FIELDS    = 1'b0,
      CSR_MAX_FIELD_LEN = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_STORE     = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_SKIP_END  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [2:0]  max_fields;
      logic [10:0] max_field_len;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  field_slot;
      logic [9:0]  position;
      logic [7:0]  char_value;
      logic        line_done;
      logic [2:0]  field_count;
   } rsp_type;

endpackage

// File: hw/rtl/csvfs_in_stage.sv
module csvfs_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_line_byte,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // Stall only while a held byte cannot move on this cycle
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_line_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// File: hw/rtl/csvfs_core.sv
module csvfs_core (
   input  logic               clock,
   input  logic               reset,
   input  csvfs_pkg::cfg_type cfg,
   input  logic               item_valid,
   input  logic [7:0]         item_byte,
   input  logic               advance,
   output logic               has_result,
   output csvfs_pkg::rsp_type result
);
   import csvfs_pkg::*;

   logic        quoted_ff,        quoted_in;
   logic [2:0]  current_field_ff, current_field_in;
   logic [9:0]  stored_count_ff,  stored_count_in;
   logic        skipping_ff,      skipping_in;

   logic [2:0]  limit;
   logic [10:0] size;
   logic [9:0]  room;
   logic        ends_line;
   logic        skip_now;

   always_comb begin
      limit     = (cfg.max_fields > FIELD_SLOTS) ? FIELD_SLOTS : cfg.max_fields;
      size      = (cfg.max_field_len > FIELD_CAPACITY) ? FIELD_CAPACITY : cfg.max_field_len;
      room      = (size == 11'd0) ? 10'd0 : 10'(size - 11'd1);
      ends_line = (item_byte == CHAR_NUL) || (item_byte == CHAR_LF) || (item_byte == CHAR_CR);
      skip_now  = skipping_ff || (current_field_ff >= limit);

      has_result         = 1'b0;
      result.kind        = KIND_STORE;
      result.field_slot  = current_field_ff;
      result.position    = stored_count_ff;
      result.char_value  = item_byte;
      result.line_done   = 1'b0;
      result.field_count = 3'd0;

      quoted_in        = quoted_ff;
      current_field_in = current_field_ff;
      stored_count_in  = stored_count_ff;
      skipping_in      = skipping_ff;

      if (skip_now) begin
         skipping_in = 1'b1;
         if (ends_line) begin
            has_result         = item_valid;
            result.kind        = KIND_SKIP_END;
            result.field_slot  = 3'd0;
            result.position    = 10'd0;
            result.char_value  = 8'd0;
            result.line_done   = 1'b1;
            result.field_count = current_field_ff;
            quoted_in          = 1'b0;
            current_field_in   = 3'd0;
            stored_count_in    = 10'd0;
            skipping_in        = 1'b0;
         end
      end else if (ends_line) begin
         has_result         = item_valid;
         result.kind        = KIND_FIELD_END;
         result.char_value  = 8'd0;
         result.line_done   = 1'b1;
         result.field_count = current_field_ff;
         quoted_in          = 1'b0;
         current_field_in   = 3'd0;
         stored_count_in    = 10'd0;
         skipping_in        = 1'b0;
      end else if ((item_byte == CHAR_COMMA) && !quoted_ff) begin
         has_result        = item_valid;
         result.kind       = KIND_FIELD_END;
         result.char_value = 8'd0;
         current_field_in  = 3'(current_field_ff + 3'd1);
         stored_count_in   = 10'd0;
         quoted_in         = 1'b0;
      end else if (item_byte == CHAR_QUOTE) begin
         quoted_in = !quoted_ff;
      end else if (stored_count_ff < room) begin
         has_result      = item_valid;
         stored_count_in = 10'(stored_count_ff + 10'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_ff        <= 1'b0;
         current_field_ff <= 3'd0;
         stored_count_ff  <= 10'd0;
         skipping_ff      <= 1'b0;
      end else if (advance) begin
         quoted_ff        <= quoted_in;
         current_field_ff <= current_field_in;
         stored_count_ff  <= stored_count_in;
         skipping_ff      <= skipping_in;
      end
   end

endmodule

// File: hw/rtl/csvfs_out_stage.sv
module csvfs_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  csvfs_pkg::rsp_type load_data,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [2:0]         rsp_field_slot,
   output logic [9:0]         rsp_position,
   output logic [7:0]         rsp_char_value,
   output logic               rsp_line_done,
   output logic [2:0]         rsp_field_count
);
   import csvfs_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = data_ff.kind;
   assign rsp_field_slot  = data_ff.field_slot;
   assign rsp_position    = data_ff.position;
   assign rsp_char_value  = data_ff.char_value;
   assign rsp_line_done   = data_ff.line_done;
   assign rsp_field_count = data_ff.field_count;

endmodule

// File: hw/rtl/csv_field_splitter.sv
// CSV field splitter: takes one byte of a text line per request and returns
// at most one result per byte: a character stored into a field buffer, a
// field terminator (on a comma outside quotes, or at line end), or a line-end
// marker when the rest of the line was skipped after max_fields fields.
// Double quotes toggle quoted mode and are dropped; NUL, LF and CR always end
// the line and return the block to the start of a new line. The block takes
// a new byte every cycle unless rsp_stall holds a result in the result
// register; a byte's result is offered on the rsp port after passing the
// input register, then the result register, and the whole per-byte step is
// one pass of the tokenizer logic between those two registers, which also
// updates the line state. Bytes that give no result (quotes, dropped
// characters, skipped bytes) still pass through the input register.
// The user must write max_fields and max_field_len through the csr port only
// while no request is in flight; not enforced. They reset to 4 and 256.
module csv_field_splitter (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_line_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_field_slot,
   output logic [9:0]  rsp_position,
   output logic [7:0]  rsp_char_value,
   output logic        rsp_line_done,
   output logic [2:0]  rsp_field_count,

   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [10:0] csr_wdata
);
   import csvfs_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;

   logic       item_valid;
   logic [7:0] item_byte;
   logic       advance;
   logic       has_result;
   rsp_type    result;
   logic       out_free;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_FIELDS: begin
               cfg_in.max_fields = csr_wdata[2:0];
            end
            CSR_MAX_FIELD_LEN: begin
               cfg_in.max_field_len = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_fields    <= MAX_FIELDS_RESET;
         cfg_ff.max_field_len <= MAX_FIELD_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A held byte moves on when it gives no result or the result register
   // has room (empty, or being emptied this cycle).
   assign advance = item_valid && (!has_result || out_free);

   csvfs_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_line_byte (req_line_byte),
      .advance       (advance),
      .item_valid    (item_valid),
      .item_byte     (item_byte)
   );

   csvfs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .advance    (advance),
      .has_result (has_result),
      .result     (result)
   );

   csvfs_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (advance && has_result),
      .load_data       (result),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_field_slot  (rsp_field_slot),
      .rsp_position    (rsp_position),
      .rsp_char_value  (rsp_char_value),
      .rsp_line_done   (rsp_line_done),
      .rsp_field_count (rsp_field_count)
   );

   // Stored characters never close a line
   a_store_not_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_STORE)) |-> !rsp_line_done)
      else $error("store request marked as line end");

   // Skip-end marker carries no slot or position and always ends the line
   a_skip_end_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_SKIP_END)) |->
      (rsp_line_done && (rsp_field_slot == 3'd0) && (rsp_position == 10'd0)))
      else $error("malformed skip-end request");

   // Any slot written lies within the field buffers
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_SKIP_END)) |-> (rsp_field_slot < FIELD_SLOTS))
      else $error("field slot out of range");

   // Input side stalls only while a byte is held and cannot move on
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid && has_result && !out_free))
      else $error("input stalled without cause");

endmodule
